@@ design/assert_macros.svh @@
// Assertion macros for the tokenizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ECT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define ECT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

@@ design/ect_pkg.sv @@
// Types, constants and character classes for the expression tokenizer
`timescale 1ns / 1ps

package ect_pkg;

  localparam int CHAR_W    = 8;
  localparam int LINE_W    = 16;
  localparam int COL_W     = 13;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 1;

  localparam int MAX_LINE = 4096;

  localparam int MAX_RESULTS = 3;
  localparam int RES_CW      = 2;

  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CW    = 4;
  localparam logic [Q_CW-1:0] Q_FREE_LIMIT = Q_CW'(Q_DEPTH - MAX_RESULTS);

  localparam logic [CFG_IDX_W-1:0] REG_ADD_END      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ERRORS = CFG_IDX_W'(1);

  localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_LT   = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT   = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_BANG = 8'h21;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_US   = 8'h5F;

  localparam logic [COL_W:0] COL_SAT = {1'b0, {COL_W{1'b1}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT  = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_SINGLE = 3'd2,
    KIND_DOUBLE = 3'd3,
    KIND_END    = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_IDENT  = 2'd1,
    CLS_NUMBER = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_CMP  = 2'd1,
    PK_BANG = 2'd2,
    PK_DOT  = 2'd3
  } pk_t;

  typedef struct packed {
    kind_t             kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [COL_W-1:0]  length;
    logic [CHAR_W-1:0] op_first;
    logic [CHAR_W-1:0] op_second;
    logic              last;
  } tok_t;

  typedef struct packed {
    cls_t              token_class;
    logic [COL_W-1:0]  token_start;
    logic              seen_dot;
    pk_t               pending_kind;
    logic [CHAR_W-1:0] pending_char;
    logic              dot_bad;
    logic [COL_W-1:0]  column_count;
    logic [LINE_W-1:0] line_count;
    logic              line_failed;
  } lex_state_t;

  typedef struct packed {
    tok_t [MAX_RESULTS-1:0] toks;
    logic [RES_CW-1:0]      count;
    logic                   fail;
  } lex_out_t;

  function automatic tok_t make_tok(kind_t k, logic [LINE_W-1:0] ln, logic [COL_W:0] col,
                                    logic [COL_W-1:0] len, logic [CHAR_W-1:0] op1,
                                    logic [CHAR_W-1:0] op2);
    tok_t t;
    t.kind      = k;
    t.line      = ln;
    t.column    = (col > COL_SAT) ? COL_SAT[COL_W-1:0] : col[COL_W-1:0];
    t.length    = len;
    t.op_first  = op1;
    t.op_second = op2;
    t.last      = 1'b0;
    return t;
  endfunction

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [CHAR_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_single(logic [CHAR_W-1:0] c);
    logic r;
    unique case (c)
      8'h28, 8'h29, 8'h2B, 8'h2D, 8'h3B, 8'h2C, 8'h2A, 8'h2F,
      8'h5E, 8'h7B, 8'h7D, 8'h7C, 8'h26, 8'h5B, 8'h5D, 8'h25: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ design/ect_if.sv @@
// Channel interfaces: characters in, tokens out, configuration writes
`timescale 1ns / 1ps

interface ect_char_if;
  logic                      valid;
  logic                      ready;
  logic [ect_pkg::CHAR_W-1:0] char_code;
  logic                      line_end;
  modport source (output valid, char_code, line_end, input ready);
  modport sink (input valid, char_code, line_end, output ready);
endinterface

interface ect_tok_if;
  logic                       valid;
  logic                       ready;
  logic [ect_pkg::KIND_W-1:0] kind;
  logic [ect_pkg::LINE_W-1:0] line;
  logic [ect_pkg::COL_W-1:0]  column;
  logic [ect_pkg::COL_W-1:0]  length;
  logic [ect_pkg::CHAR_W-1:0] op_first;
  logic [ect_pkg::CHAR_W-1:0] op_second;
  logic                       last;
  modport source (output valid, kind, line, column, length, op_first, op_second, last,
                  input ready);
  modport sink (input valid, kind, line, column, length, op_first, op_second, last,
                output ready);
endinterface

interface ect_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ect_pkg::CFG_IDX_W-1:0] index;
  logic [ect_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/expression_char_tokenizer.sv @@
// Expression line tokenizer, one character or line end per transaction.
// Each transaction is registered, lexed from the holding register once the queue has room,
// and its tokens (up to three) go into an 8-entry queue that offers its head when not empty.
// The block takes one transaction per cycle while the queue has room for three more tokens,
// and the queue hands out one token per cycle while tokens.ready is high, so sustained
// throughput is one transaction per cycle whenever tokens.ready stays high and lines average
// at most one token per character. Configuration writes are registered and are accepted in every cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module expression_char_tokenizer (
  input logic       clk,
  input logic       rst,
  ect_char_if.sink  chars,
  ect_tok_if.source tokens,
  ect_cfg_if.sink   cfg
);

  logic                       hold_valid;
  logic [ect_pkg::CHAR_W-1:0] hold_char;
  logic                       hold_end;
  logic                       advance;
  logic                       add_end;
  logic                       check_errors;
  logic [ect_pkg::Q_CW-1:0]   q_count;
  logic [ect_pkg::RES_CW-1:0] wr_count;
  ect_pkg::lex_out_t          lex;

  assign advance     = hold_valid && (q_count <= ect_pkg::Q_FREE_LIMIT);
  assign chars.ready = !hold_valid || advance;
  assign wr_count    = advance ? lex.count : '0;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (chars.ready) begin
      hold_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      hold_char <= chars.char_code;
      hold_end  <= chars.line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      add_end      <= 1'b0;
      check_errors <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == ect_pkg::REG_ADD_END) begin
        add_end <= cfg.data[0];
      end
      if (cfg.index == ect_pkg::REG_CHECK_ERRORS) begin
        check_errors <= cfg.data[0];
      end
    end
  end

  ect_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .char_code    (hold_char),
    .line_end     (hold_end),
    .add_end      (add_end),
    .check_errors (check_errors),
    .result       (lex)
  );

  ect_tok_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_toks  (lex.toks),
    .count    (q_count),
    .tokens   (tokens)
  );

  // queue never overfills
  `ECT_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= ect_pkg::Q_CW'(ect_pkg::Q_DEPTH))
  // occupancy tracks tokens written and taken
  `ECT_ASSERT_NEXT(a_queue_count, 1'b1,
                   q_count == $past(q_count) + ect_pkg::Q_CW'($past(wr_count)) -
                              ect_pkg::Q_CW'($past(tokens.valid && tokens.ready)))
  // after an error, the next character on the line yields no token
  `ECT_ASSERT_NEXT(a_fail_mutes, advance && lex.fail && !hold_end,
                   !(advance && !hold_end && lex.count != '0))

endmodule

@@ design/ect_lexer.sv @@
// Lexer state and per-character token decisions
`timescale 1ns / 1ps

module ect_lexer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [ect_pkg::CHAR_W-1:0] char_code,
  input  logic                       line_end,
  input  logic                       add_end,
  input  logic                       check_errors,
  output ect_pkg::lex_out_t          result
);

  ect_pkg::lex_state_t st;
  ect_pkg::lex_state_t st_next;

  logic [ect_pkg::COL_W:0]    col;
  logic [ect_pkg::COL_W:0]    fail_col;
  logic [ect_pkg::LINE_W-1:0] err_line;
  logic                       ovf;
  logic                       stop;
  logic                       flush_req;
  logic                       single_req;
  logic                       fail_req;
  logic [ect_pkg::RES_CW-1:0] n;
  ect_pkg::tok_t [ect_pkg::MAX_RESULTS-1:0] toks;

  always_comb begin
    st_next    = st;
    toks       = '0;
    n          = '0;
    stop       = 1'b0;
    flush_req  = 1'b0;
    single_req = 1'b0;
    fail_req   = 1'b0;
    fail_col   = '0;
    col        = {1'b0, st.column_count} + 1'b1;
    ovf        = st.column_count >= ect_pkg::COL_W'(ect_pkg::MAX_LINE);
    err_line   = add_end ? ect_pkg::LINE_W'(1) : st.line_count;

    if (!line_end) begin
      if (!st.line_failed) begin
        st_next.pending_kind = ect_pkg::PK_NONE;
        unique case (st.pending_kind)
          ect_pkg::PK_CMP: begin
            if (char_code == ect_pkg::CH_EQ && !ovf) begin
              toks[n] = ect_pkg::make_tok(ect_pkg::KIND_DOUBLE, st.line_count, col - 1'b1,
                                          ect_pkg::COL_W'(2), st.pending_char, ect_pkg::CH_EQ);
              n = n + 1'b1;
              stop = 1'b1;
            end else begin
              toks[n] = ect_pkg::make_tok(ect_pkg::KIND_SINGLE, st.line_count, col - 1'b1,
                                          ect_pkg::COL_W'(1), st.pending_char, '0);
              n = n + 1'b1;
            end
            st_next.pending_char = '0;
          end
          ect_pkg::PK_BANG: begin
            stop = 1'b1;
            if (char_code == ect_pkg::CH_EQ && !ovf) begin
              toks[n] = ect_pkg::make_tok(ect_pkg::KIND_DOUBLE, st.line_count, col - 1'b1,
                                          ect_pkg::COL_W'(2), ect_pkg::CH_BANG, ect_pkg::CH_EQ);
              n = n + 1'b1;
            end else begin
              fail_req = 1'b1;
              fail_col = col - 1'b1;
            end
          end
          ect_pkg::PK_DOT: begin
            if (ovf || !ect_pkg::is_digit(char_code)) begin
              stop     = 1'b1;
              fail_req = 1'b1;
              fail_col = col;
            end else if (st.dot_bad) begin
              stop     = 1'b1;
              fail_req = 1'b1;
              fail_col = col - 1'b1;
            end else begin
              st_next.seen_dot = 1'b1;
              st_next.dot_bad  = 1'b0;
            end
          end
          ect_pkg::PK_NONE: ;
        endcase

        if (!stop) begin
          priority if (ovf) begin
            fail_req = 1'b1;
            fail_col = col;
          end else if (ect_pkg::is_single(char_code)) begin
            flush_req  = 1'b1;
            single_req = 1'b1;
          end else if (char_code == ect_pkg::CH_EQ || char_code == ect_pkg::CH_LT ||
                       char_code == ect_pkg::CH_GT) begin
            flush_req            = 1'b1;
            st_next.pending_kind = ect_pkg::PK_CMP;
            st_next.pending_char = char_code;
          end else if (char_code == ect_pkg::CH_BANG) begin
            flush_req            = 1'b1;
            st_next.pending_kind = ect_pkg::PK_BANG;
          end else if (ect_pkg::is_space(char_code)) begin
            flush_req = 1'b1;
          end else if (char_code == ect_pkg::CH_DOT) begin
            st_next.dot_bad      = (st_next.token_class != ect_pkg::CLS_NUMBER) ||
                                   st_next.seen_dot;
            st_next.pending_kind = ect_pkg::PK_DOT;
          end else if (ect_pkg::is_digit(char_code)) begin
            if (st_next.token_class == ect_pkg::CLS_NONE) begin
              st_next.token_class = ect_pkg::CLS_NUMBER;
              st_next.token_start = col[ect_pkg::COL_W-1:0];
              st_next.seen_dot    = 1'b0;
            end
          end else if (ect_pkg::is_alpha(char_code) || char_code == ect_pkg::CH_US) begin
            if (st_next.token_class == ect_pkg::CLS_NUMBER) begin
              fail_req = 1'b1;
              fail_col = col;
            end else if (st_next.token_class == ect_pkg::CLS_NONE) begin
              st_next.token_class = ect_pkg::CLS_IDENT;
              st_next.token_start = col[ect_pkg::COL_W-1:0];
            end
          end else begin
            fail_req = 1'b1;
            fail_col = col;
          end
        end
      end
      if (!ovf) begin
        st_next.column_count = st.column_count + 1'b1;
      end
    end else begin
      if (!st.line_failed) begin
        unique case (st.pending_kind)
          ect_pkg::PK_CMP: begin
            toks[n] = ect_pkg::make_tok(ect_pkg::KIND_SINGLE, st.line_count, col - 1'b1,
                                        ect_pkg::COL_W'(1), st.pending_char, '0);
            n = n + 1'b1;
          end
          ect_pkg::PK_BANG: begin
            fail_req = 1'b1;
            fail_col = col - 1'b1;
          end
          ect_pkg::PK_DOT: begin
            fail_req = 1'b1;
            fail_col = col;
          end
          ect_pkg::PK_NONE: ;
        endcase
        flush_req = !fail_req;
      end
    end

    if (flush_req) begin
      if (st_next.token_class != ect_pkg::CLS_NONE) begin
        toks[n] = ect_pkg::make_tok(
          (st_next.token_class == ect_pkg::CLS_IDENT) ? ect_pkg::KIND_IDENT
                                                      : ect_pkg::KIND_NUMBER,
          st.line_count, {1'b0, st_next.token_start},
          ect_pkg::COL_W'(col - {1'b0, st_next.token_start}), '0, '0);
        n = n + 1'b1;
      end
      st_next.token_class = ect_pkg::CLS_NONE;
      st_next.seen_dot    = 1'b0;
    end

    if (single_req) begin
      toks[n] = ect_pkg::make_tok(ect_pkg::KIND_SINGLE, st.line_count, col,
                                  ect_pkg::COL_W'(1), char_code, '0);
      n = n + 1'b1;
    end

    if (fail_req) begin
      toks[n] = ect_pkg::make_tok(ect_pkg::KIND_ERROR, err_line, fail_col, '0, '0, '0);
      n = n + 1'b1;
      st_next.line_failed  = 1'b1;
      st_next.token_class  = ect_pkg::CLS_NONE;
      st_next.seen_dot     = 1'b0;
      st_next.pending_kind = ect_pkg::PK_NONE;
      st_next.pending_char = '0;
      st_next.dot_bad      = 1'b0;
    end

    if (line_end) begin
      if (add_end && !(st_next.line_failed && check_errors)) begin
        toks[n] = ect_pkg::make_tok(ect_pkg::KIND_END, st.line_count, col, '0, '0, '0);
        n = n + 1'b1;
      end
      st_next.token_class  = ect_pkg::CLS_NONE;
      st_next.token_start  = '0;
      st_next.seen_dot     = 1'b0;
      st_next.pending_kind = ect_pkg::PK_NONE;
      st_next.pending_char = '0;
      st_next.dot_bad      = 1'b0;
      st_next.column_count = '0;
      st_next.line_failed  = 1'b0;
      if (st.line_count != {ect_pkg::LINE_W{1'b1}}) begin
        st_next.line_count = st.line_count + 1'b1;
      end
    end

    if (n != '0) begin
      toks[n - 1'b1].last = 1'b1;
    end

    result.toks  = toks;
    result.count = n;
    result.fail  = fail_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.token_class  <= ect_pkg::CLS_NONE;
      st.token_start  <= '0;
      st.seen_dot     <= 1'b0;
      st.pending_kind <= ect_pkg::PK_NONE;
      st.pending_char <= '0;
      st.dot_bad      <= 1'b0;
      st.column_count <= '0;
      st.line_count   <= ect_pkg::LINE_W'(1);
      st.line_failed  <= 1'b0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

@@ design/ect_tok_queue.sv @@
// Token queue: takes up to three tokens a cycle, hands out one a cycle while the sink is ready
`timescale 1ns / 1ps

module ect_tok_queue (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [ect_pkg::RES_CW-1:0]               wr_count,
  input  ect_pkg::tok_t [ect_pkg::MAX_RESULTS-1:0] wr_toks,
  output logic [ect_pkg::Q_CW-1:0]                 count,
  ect_tok_if.source                                tokens
);

  ect_pkg::tok_t q [ect_pkg::Q_DEPTH];

  logic [ect_pkg::Q_AW-1:0] wptr;
  logic [ect_pkg::Q_AW-1:0] rptr;
  logic                     pop;
  ect_pkg::tok_t            head;

  assign pop  = tokens.valid && tokens.ready;
  assign head = q[rptr];

  assign tokens.valid     = count != '0;
  assign tokens.kind      = head.kind;
  assign tokens.line      = head.line;
  assign tokens.column    = head.column;
  assign tokens.length    = head.length;
  assign tokens.op_first  = head.op_first;
  assign tokens.op_second = head.op_second;
  assign tokens.last      = head.last;

  always_ff @(posedge clk) begin
    for (int i = 0; i < ect_pkg::MAX_RESULTS; i++) begin
      if (ect_pkg::RES_CW'(i) < wr_count) begin
        q[wptr + ect_pkg::Q_AW'(i)] <= wr_toks[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + ect_pkg::Q_AW'(wr_count);
      rptr  <= rptr + ect_pkg::Q_AW'(pop);
      count <= count + ect_pkg::Q_CW'(wr_count) - ect_pkg::Q_CW'(pop);
    end
  end

endmodule
